// ===== src/bounded_stack_with_age_purge_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded stack with age purge unit
// Shared property forms used by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_AGE_PURGE_UNIT_DEFINES_SVH
`define BOUNDED_STACK_WITH_AGE_PURGE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSAP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsap: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BSAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsap: next-cycle check failed");

`endif

// ===== src/bsap_pkg.sv =====
// ----------------------------------------------------------------------------
// bsap_pkg
// Types, constants and helpers of the bounded stack with age purge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bsap_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] ACT_PUSH  = 3'd0;
    localparam logic [2:0] ACT_POP   = 3'd1;
    localparam logic [2:0] ACT_PEEK  = 3'd2;
    localparam logic [2:0] ACT_COUNT = 3'd3;
    localparam logic [2:0] ACT_PURGE = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic signed [31:0] id;
        logic signed [31:0] qty;
        logic [26:0]        expiry;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic start;    // input transfer this cycle
        logic scan;     // walking the stack for count or purge
        logic load;     // capture the result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic scan_last;
    } stat_t;

    function automatic logic [7:0] level_to_byte(input logic [LEVEL_W-1:0] v);
        logic [LEVEL_W+7:0] ext;
        ext = {8'd0, v};
        return ext[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/bsap_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsap_ctrl
// Sequencer: accepts one action, runs the walk for count and purge, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_stack_with_age_purge_unit_defines.svh"

module bsap_ctrl
    import bsap_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] action,
    output logic            out_valid,
    input  wire logic       out_stall,
    output cmd_t            cmd,
    input  wire stat_t      stat
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((action inside {ACT_COUNT, ACT_PURGE}) && !stat.empty)
                        state_next = S_SCAN;
                    else
                        state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        cmd.start = accept;
        cmd.scan  = (state_reg == S_SCAN);
        cmd.load  = (state_reg == S_RESP) && out_free;
        // hold the result until its transfer, reload when a new one lands
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BSAP_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_reg != S_IDLE)
    `BSAP_ASSERT_NEXT(a_scan_holds, clk, rst_n,
                      (state_reg == S_SCAN) && !stat.scan_last, state_reg == S_SCAN)
    `BSAP_ASSERT_NEXT(a_load_shows_result, clk, rst_n, cmd.load, out_valid_reg)

endmodule

`default_nettype wire

// ===== src/bsap_datapath.sv =====
// ----------------------------------------------------------------------------
// bsap_datapath
// Entry memory, fill level, walk counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_stack_with_age_purge_unit_defines.svh"

module bsap_datapath
    import bsap_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic [2:0]         action,
    input  wire logic signed [31:0] item_id,
    input  wire logic signed [31:0] quantity,
    input  wire logic [26:0]        expiry_date,
    input  wire logic [26:0]        current_date,
    output logic [1:0]              status,
    output logic signed [31:0]      entry_id,
    output logic signed [31:0]      entry_quantity,
    output logic [26:0]             entry_expiry,
    output logic [7:0]              expired_count,
    output logic [7:0]              occupancy
);

    entry_t mem [STACK_DEPTH];
    entry_t rd_data_reg;

    logic [LEVEL_W-1:0] fill_reg;
    logic [LEVEL_W-1:0] fill_next;
    logic [LEVEL_W-1:0] k_reg;
    logic [LEVEL_W-1:0] k_next;
    logic [LEVEL_W-1:0] w_reg;
    logic [LEVEL_W-1:0] w_next;
    logic [LEVEL_W-1:0] cnt_reg;
    logic [LEVEL_W-1:0] cnt_next;
    logic [LEVEL_W-1:0] fill_m1;
    logic [2:0]         op_reg;
    logic [1:0]         status_reg;
    logic [26:0]        date_reg;

    logic               full;
    logic               empty;
    logic               scan_last;
    logic               expired;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    entry_t             wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [1:0]         status_new;
    logic               show_entry;

    assign full      = (fill_reg == LEVEL_W'(STACK_DEPTH));
    assign empty     = (fill_reg == '0);
    assign fill_m1   = fill_reg - LEVEL_W'(1);
    assign scan_last = (k_reg == fill_reg);
    assign expired   = (rd_data_reg.expiry < date_reg);

    assign stat.empty     = empty;
    assign stat.scan_last = scan_last;

    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = fill_reg[ADDR_W-1:0];
        wr_data    = '{id: item_id, qty: quantity, expiry: expiry_date};
        rd_en      = 1'b0;
        rd_addr    = '0;
        status_new = ST_OK;
        fill_next  = fill_reg;
        k_next     = k_reg;
        w_next     = w_reg;
        cnt_next   = cnt_reg;

        if (cmd.start)
        begin
            k_next   = LEVEL_W'(1);
            w_next   = '0;
            cnt_next = '0;
            case (action)
                ACT_PUSH:
                begin
                    if (full)
                        status_new = ST_FULL;
                    else
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + LEVEL_W'(1);
                    end
                end
                ACT_POP, ACT_PEEK:
                begin
                    if (empty)
                        status_new = ST_EMPTY;
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = fill_m1[ADDR_W-1:0];
                        if (action == ACT_POP)
                            fill_next = fill_m1;
                    end
                end
                ACT_COUNT, ACT_PURGE:
                begin
                    // first read of the walk goes out with the transfer
                    rd_en = !empty;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.scan)
        begin
            if (expired)
                cnt_next = cnt_reg + LEVEL_W'(1);
            else if (op_reg == ACT_PURGE)
            begin
                // compact the survivor down to the write pointer
                wr_en   = 1'b1;
                wr_addr = w_reg[ADDR_W-1:0];
                wr_data = rd_data_reg;
                w_next  = w_reg + LEVEL_W'(1);
            end
            if (scan_last)
            begin
                if (op_reg == ACT_PURGE)
                    fill_next = w_next;
            end
            else
            begin
                rd_en   = 1'b1;
                rd_addr = k_reg[ADDR_W-1:0];
                k_next  = k_reg + LEVEL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            k_reg    <= '0;
            w_reg    <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            k_reg    <= k_next;
            w_reg    <= w_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg     <= action;
            status_reg <= status_new;
            date_reg   <= current_date;
        end
    end

    assign show_entry = ((op_reg == ACT_POP) || (op_reg == ACT_PEEK)) && (status_reg == ST_OK);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status         <= status_reg;
            entry_id       <= show_entry ? rd_data_reg.id : 32'sd0;
            entry_quantity <= show_entry ? rd_data_reg.qty : 32'sd0;
            entry_expiry   <= show_entry ? rd_data_reg.expiry : 27'd0;
            expired_count  <= (op_reg inside {ACT_COUNT, ACT_PURGE}) ?
                              level_to_byte(cnt_reg) : 8'd0;
            occupancy      <= level_to_byte(fill_reg);
        end
    end

    `BSAP_ASSERT_NOW(a_fill_bounded, clk, rst_n, 1'b1, fill_reg <= LEVEL_W'(STACK_DEPTH))
    `BSAP_ASSERT_NOW(a_walk_in_range, clk, rst_n, cmd.scan,
                     (k_reg != '0) && (k_reg <= fill_reg))
    `BSAP_ASSERT_NOW(a_write_behind_read, clk, rst_n, cmd.scan,
                     (w_reg < k_reg) && (cnt_reg < k_reg))

endmodule

`default_nettype wire

// ===== src/bounded_stack_with_age_purge_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_age_purge_unit
// Bounded LIFO stack of entries with expiry count and order-keeping purge.
// ----------------------------------------------------------------------------
// Each accepted action returns one result. Push, pop, peek and unknown codes
// go from S_IDLE through S_RESP, where the result is loaded into the output
// register once that register is free, and back to S_IDLE to take the next
// action. Count and purge on a non-empty stack pass through S_SCAN first,
// which walks the held entries, reading the entry memory one entry per cycle
// (purge writes survivors back through the memory's write port in the
// same pass). A new action is taken once the previous result sits in
// the output register, even if that result is still stalled. The entry
// memory needs no clearing pass: only slots below the fill level are read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_age_purge_unit
    import bsap_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         action,
    input  wire logic signed [31:0] item_id,
    input  wire logic signed [31:0] quantity,
    input  wire logic [26:0]        expiry_date,
    input  wire logic [26:0]        current_date,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic signed [31:0]      entry_id,
    output logic signed [31:0]      entry_quantity,
    output logic [26:0]             entry_expiry,
    output logic [7:0]              expired_count,
    output logic [7:0]              occupancy
);

    cmd_t  cmd;
    stat_t stat;

    bsap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    bsap_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .action         (action),
        .item_id        (item_id),
        .quantity       (quantity),
        .expiry_date    (expiry_date),
        .current_date   (current_date),
        .status         (status),
        .entry_id       (entry_id),
        .entry_quantity (entry_quantity),
        .entry_expiry   (entry_expiry),
        .expired_count  (expired_count),
        .occupancy      (occupancy)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded stack with age purge unit. A short
// table of directed actions covers empty stacks, extreme fields, equal
// dates and reserved codes. Random actions follow under several
// idle/stall patterns, with a full stack and a long output hold-off.
// Results are checked against table replies or an in-bench stack model.
// ----------------------------------------------------------------------------
module tb_top;
    import bsap_pkg::*;

    localparam logic [2:0]         ACT_RESERVED_FIRST = 3'd5;
    localparam logic [2:0]         ACT_RESERVED_LAST  = 3'd7;
    localparam logic [26:0]        DATE_MAX           = 27'd99999999;
    localparam logic [26:0]        DATE_BASE          = 27'd20240101;
    localparam logic signed [31:0] ID_MIN             = 32'sh8000_0000;
    localparam logic signed [31:0] ID_MAX             = 32'sh7FFF_FFFF;
    localparam int                 WATCHDOG_LIMIT     = 5000;
    localparam int                 LONG_HOLD          = 400;
    localparam int                 REPORT_LIMIT       = 10;
    localparam int                 ITEMS_PER_MODE     = 120;
    localparam int                 PRESSURE_ITEMS     = 12;
    localparam int                 NUM_PLAN           = 22;

    typedef struct packed {
        logic [2:0]         act;
        logic signed [31:0] id;
        logic signed [31:0] qty;
        logic [26:0]        expiry;
        logic [26:0]        today;
    } stack_op_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] id;
        logic signed [31:0] qty;
        logic [26:0]        expiry;
        logic [7:0]         expired;
        logic [7:0]         occ;
    } stack_reply_t;

    typedef struct packed {
        stack_op_t    op;
        logic         has_reply;
        stack_reply_t reply;
    } plan_row_t;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic [2:0]         action         = ACT_PUSH;
    logic signed [31:0] item_id        = '0;
    logic signed [31:0] quantity       = '0;
    logic [26:0]        expiry_date    = '0;
    logic [26:0]        current_date   = '0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] entry_id;
    logic signed [31:0] entry_quantity;
    logic [26:0]        entry_expiry;
    logic [7:0]         expired_count;
    logic [7:0]         occupancy;

    bounded_stack_with_age_purge_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .item_id        (item_id),
        .quantity       (quantity),
        .expiry_date    (expiry_date),
        .current_date   (current_date),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .entry_id       (entry_id),
        .entry_quantity (entry_quantity),
        .entry_expiry   (entry_expiry),
        .expired_count  (expired_count),
        .occupancy      (occupancy)
    );

    always #1 clk = ~clk;

    // Model of the stack contents
    entry_t       shelf [STACK_DEPTH];
    int           shelf_level = 0;
    stack_reply_t reply_q [$];

    plan_row_t    plan [NUM_PLAN];
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    logic         hold_req       = 1'b0;
    int           hold_left      = 0;
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    stack_reply_t seen_reply;
    stack_reply_t wanted_reply;

    function automatic stack_reply_t apply_stack_op(input stack_op_t op);
        stack_reply_t r;
        int           kept;
        int           k;
        r = '0;
        case (op.act)
            ACT_PUSH:
            begin
                if (shelf_level >= STACK_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shelf[shelf_level] = '{op.id, op.qty, op.expiry};
                    shelf_level++;
                end
            end
            ACT_POP, ACT_PEEK:
            begin
                if (shelf_level == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.id     = shelf[shelf_level - 1].id;
                    r.qty    = shelf[shelf_level - 1].qty;
                    r.expiry = shelf[shelf_level - 1].expiry;
                    if (op.act == ACT_POP)
                        shelf_level--;
                end
            end
            ACT_COUNT:
            begin
                for (k = 0; k < shelf_level; k++)
                    if (shelf[k].expiry < op.today)
                        r.expired++;
            end
            ACT_PURGE:
            begin
                // compact survivors downward, keeping bottom-to-top order
                kept = 0;
                for (k = 0; k < shelf_level; k++)
                begin
                    if (shelf[k].expiry < op.today)
                        r.expired++;
                    else
                    begin
                        shelf[kept] = shelf[k];
                        kept++;
                    end
                end
                shelf_level = kept;
            end
            default:
            begin
            end
        endcase
        r.occ = 8'(shelf_level);
        return r;
    endfunction

    // Mostly dates near a common base so that count and purge split the stack
    function automatic logic [26:0] random_date();
        logic [26:0] d;
        case ($urandom_range(7))
            0:       d = 27'($urandom_range(DATE_MAX));
            1:       d = $urandom_range(1) ? DATE_MAX : 27'd0;
            default: d = DATE_BASE + 27'($urandom_range(600));
        endcase
        return d;
    endfunction

    function automatic stack_op_t random_stack_op();
        stack_op_t op;
        int        pick;
        pick      = $urandom_range(99);
        op.id     = $urandom();
        op.qty    = $urandom();
        op.expiry = random_date();
        op.today  = random_date();
        if (pick < 38)
            op.act = ACT_PUSH;
        else if (pick < 56)
            op.act = ACT_POP;
        else if (pick < 66)
            op.act = ACT_PEEK;
        else if (pick < 78)
            op.act = ACT_COUNT;
        else if (pick < 90)
            op.act = ACT_PURGE;
        else
            op.act = 3'($urandom_range(ACT_RESERVED_LAST, ACT_RESERVED_FIRST));
        return op;
    endfunction

    // Entered and left at a falling edge; valid stays high into the next call
    task automatic send_op(input stack_op_t op, input logic has_reply,
                           input stack_reply_t given);
        stack_reply_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        action       <= op.act;
        item_id      <= op.id;
        quantity     <= op.qty;
        expiry_date  <= op.expiry;
        current_date <= op.today;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_stack_op(op);
        reply_q.push_back(has_reply ? given : predicted);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic note_mismatch(input string what, input stack_reply_t want,
                                 input stack_reply_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: status %0d/%0d id %0d/%0d qty %0d/%0d exp %0d/%0d cnt %0d/%0d occ %0d/%0d (expected/actual)",
                     $realtime, what, want.status, got.status, want.id, got.id,
                     want.qty, got.qty, want.expiry, got.expiry,
                     want.expired, got.expired, want.occ, got.occ);
    endtask

    // Receiver: random stall, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req <= 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_reply = '{status, entry_id, entry_quantity, entry_expiry,
                           expired_count, occupancy};
            if (reply_q.size() == 0)
                note_mismatch("result with nothing pending", '0, seen_reply);
            else
            begin
                wanted_reply = reply_q.pop_front();
                if (seen_reply !== wanted_reply)
                    note_mismatch("result differs", wanted_reply, seen_reply);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int        row;
        int        mode;
        int        k;
        int        fill_count;
        stack_op_t op;

        plan[0]  = '{'{ACT_POP, 0, 0, 0, 0}, 1'b1, '{ST_EMPTY, 0, 0, 0, 0, 0}};
        plan[1]  = '{'{ACT_PEEK, 0, 0, 0, 0}, 1'b1, '{ST_EMPTY, 0, 0, 0, 0, 0}};
        plan[2]  = '{'{ACT_COUNT, 0, 0, 0, DATE_MAX}, 1'b1, '{ST_OK, 0, 0, 0, 0, 0}};
        plan[3]  = '{'{ACT_PURGE, 0, 0, 0, DATE_MAX}, 1'b1, '{ST_OK, 0, 0, 0, 0, 0}};
        plan[4]  = '{'{ACT_RESERVED_FIRST, ID_MAX, ID_MAX, DATE_MAX, DATE_MAX}, 1'b1,
                     '{ST_OK, 0, 0, 0, 0, 0}};
        plan[5]  = '{'{ACT_PUSH, ID_MIN, ID_MAX, 0, DATE_MAX}, 1'b1,
                     '{ST_OK, 0, 0, 0, 0, 8'd1}};
        plan[6]  = '{'{ACT_PUSH, ID_MAX, ID_MIN, DATE_MAX, 0}, 1'b1,
                     '{ST_OK, 0, 0, 0, 0, 8'd2}};
        plan[7]  = '{'{ACT_PUSH, 0, 0, DATE_BASE, 0}, 1'b0, '0};
        plan[8]  = '{'{ACT_PEEK, 0, 0, 0, 0}, 1'b0, '0};
        // expiry equal to the date is not expired
        plan[9]  = '{'{ACT_COUNT, 0, 0, 0, DATE_BASE}, 1'b0, '0};
        plan[10] = '{'{ACT_COUNT, 0, 0, 0, 0}, 1'b1, '{ST_OK, 0, 0, 0, 0, 8'd3}};
        plan[11] = '{'{ACT_PURGE, 0, 0, 0, DATE_BASE}, 1'b0, '0};
        plan[12] = '{'{ACT_PEEK, 0, 0, 0, 0}, 1'b0, '0};
        plan[13] = '{'{ACT_POP, 0, 0, 0, 0}, 1'b0, '0};
        plan[14] = '{'{ACT_POP, 0, 0, 0, 0}, 1'b1,
                     '{ST_OK, ID_MAX, ID_MIN, DATE_MAX, 0, 0}};
        plan[15] = '{'{ACT_POP, 0, 0, 0, 0}, 1'b1, '{ST_EMPTY, 0, 0, 0, 0, 0}};
        plan[16] = '{'{ACT_RESERVED_LAST, -1, -1, DATE_MAX, DATE_MAX}, 1'b1,
                     '{ST_OK, 0, 0, 0, 0, 0}};
        plan[17] = '{'{ACT_PUSH, 1, -1, 27'd5, 0}, 1'b0, '0};
        plan[18] = '{'{ACT_PUSH, 2, -1, 27'd3, 0}, 1'b0, '0};
        plan[19] = '{'{ACT_PUSH, 3, -1, 27'd9, 0}, 1'b0, '0};
        plan[20] = '{'{ACT_PURGE, 0, 0, 0, DATE_MAX}, 1'b0, '0};
        plan[21] = '{'{ACT_PEEK, 0, 0, 0, 0}, 1'b1, '{ST_EMPTY, 0, 0, 0, 0, 0}};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < NUM_PLAN; row++)
            send_op(plan[row].op, plan[row].has_reply, plan[row].reply);
        wait_for_drain();

        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 63;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 63;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            for (k = 0; k < ITEMS_PER_MODE; k++)
                send_op(random_stack_op(), 1'b0, '0);

            if (mode == 0)
            begin
                // fill to capacity, push past it, then walk a full stack
                fill_count = STACK_DEPTH - shelf_level + 3;
                for (k = 0; k < fill_count; k++)
                begin
                    op     = random_stack_op();
                    op.act = ACT_PUSH;
                    send_op(op, 1'b0, '0);
                end
                op       = random_stack_op();
                op.act   = ACT_COUNT;
                op.today = DATE_MAX;
                send_op(op, 1'b0, '0);
                op.act   = ACT_PURGE;
                op.today = DATE_BASE + 27'd300;
                send_op(op, 1'b0, '0);
                wait_for_drain();

                // hold the output off while the sender keeps offering
                hold_req <= 1'b1;
                for (k = 0; k < PRESSURE_ITEMS; k++)
                    send_op(random_stack_op(), 1'b0, '0);
            end
            wait_for_drain();
        end

        repeat (STACK_DEPTH + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
